// ----- design/tdpg_pkg.sv -----
// shared types and constants for the trial division prime generator
package tdpg_pkg;

   localparam int CSR_INDEX_W = 1;
   localparam int RESULT_W    = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_LIMIT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_MODE   = 1'd1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_FETCH = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_SDIV  = 6'b010000,
      ST_DIV   = 6'b100000
   } state_type;

endpackage

// ----- design/tdpg_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
module tdpg_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             running_ff, running_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   trial;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      if (start) begin
         running_in = 1'b1;
         cnt_in     = CNT_W'(WIDTH);
         quo_in     = dividend;
         rem_in     = '0;
         dvs_in     = divisor;
      end else if (running_ff) begin
         rem_in = fits ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
         quo_in = {quo_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ----- design/trial_division_prime_generator.sv -----
// top level of the trial division prime generator
//
//   channel   ports                                        handshake
//   request   start, busy, req_restart                     start while busy low
//   result    rsp_strobe, rsp_prime_value, rsp_prime_total, rsp_is_done
//                                                          one-cycle strobe
//   config    csr_we, csr_index, csr_wdata                 write enable
//
// one item walks candidates until a prime or the limit; each trial divisor
// costs one divide, preceded by a read of the prime table when the divisor is
// read from the table. the divider is the single shared unit and sets the rate.
// reset is synchronous; the prime table needs no clearing pass after reset.
// results cannot be held off, so the block never stalls on the output side.
module trial_division_prime_generator
   import tdpg_pkg::*;
#(
   parameter int VALUE_BITS  = 32,
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_restart,
   output logic                   rsp_strobe,
   output logic [RESULT_W-1:0]    rsp_prime_value,
   output logic [RESULT_W-1:0]    rsp_prime_total,
   output logic                   rsp_is_done,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

   state_type state_ff, state_in;

   logic [VALUE_BITS-1:0] upper_ff, upper_in;
   logic                  fast_ff, fast_in;
   logic [VALUE_BITS-1:0] next_ff, next_in;
   logic                  spent_ff, spent_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [VALUE_BITS-1:0] divisor_ff, divisor_in;
   logic [VALUE_BITS-1:0] last_entry_ff, last_entry_in;
   logic [VALUE_BITS-1:0] latest_ff, latest_in;
   logic [RESULT_W-1:0]   count_ff, count_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  table_mode_ff, table_mode_in;

   logic                  strobe_ff, strobe_in;
   logic [RESULT_W-1:0]   value_ff, value_in;
   logic [RESULT_W-1:0]   total_ff, total_in;
   logic                  done_ff, done_in;

   logic [VALUE_BITS-1:0] prime_mem [TABLE_DEPTH];
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic                  mem_we;

   logic                  div_start;
   logic                  div_done;
   logic [VALUE_BITS-1:0] quotient;
   logic [VALUE_BITS-1:0] remainder;

   logic [63:0]           wdata_wide;
   logic [63:0]           cand_wide;
   logic [63:0]           latest_wide;
   logic [FILL_W-1:0]     idx_next;
   logic [RESULT_W-1:0]   count_inc;

   assign wdata_wide  = 64'(csr_wdata);
   assign cand_wide   = 64'(cand_ff);
   assign latest_wide = 64'(latest_ff);
   assign idx_next    = FILL_W'(idx_ff) + FILL_W'(1);
   assign count_inc   = count_ff + RESULT_W'(1);

   tdpg_divider #(
      .WIDTH (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         prime_mem[fill_ff[IDX_W-1:0]] <= cand_ff;
      end
      rd_data_ff <= prime_mem[idx_ff];
   end

   always_comb begin
      state_in      = state_ff;
      upper_in      = upper_ff;
      fast_in       = fast_ff;
      next_in       = next_ff;
      spent_in      = spent_ff;
      cand_in       = cand_ff;
      divisor_in    = divisor_ff;
      last_entry_in = last_entry_ff;
      latest_in     = latest_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      table_mode_in = table_mode_ff;
      strobe_in     = 1'b0;
      value_in      = value_ff;
      total_in      = total_ff;
      done_in       = done_ff;
      mem_we        = 1'b0;
      div_start     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_UPPER_LIMIT: upper_in = wdata_wide[VALUE_BITS-1:0];
            CSR_FAST_MODE:   fast_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_restart) begin
                  next_in   = VALUE_BITS'(2);
                  fill_in   = '0;
                  count_in  = '0;
                  latest_in = '0;
                  spent_in  = 1'b0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!spent_ff && next_ff <= upper_ff) begin
               cand_in = next_ff;
               if (next_ff == '1) begin
                  spent_in = 1'b1;
               end else begin
                  next_in = next_ff + VALUE_BITS'(1);
               end
               if (fast_ff && fill_ff != '0) begin
                  table_mode_in = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_FETCH;
               end else begin
                  table_mode_in = 1'b0;
                  divisor_in    = VALUE_BITS'(2);
                  state_in      = ST_SDIV;
               end
            end else begin
               strobe_in = 1'b1;
               value_in  = latest_wide[RESULT_W-1:0];
               total_in  = count_ff;
               done_in   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            divisor_in = rd_data_ff;
            state_in   = ST_SDIV;
         end
         ST_SDIV: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (divisor_ff > quotient) begin
                  count_in  = count_inc;
                  latest_in = cand_ff;
                  if (fill_ff < FILL_W'(TABLE_DEPTH)) begin
                     mem_we        = 1'b1;
                     fill_in       = fill_ff + FILL_W'(1);
                     last_entry_in = cand_ff;
                  end
                  strobe_in = 1'b1;
                  value_in  = cand_wide[RESULT_W-1:0];
                  total_in  = count_inc;
                  done_in   = 1'b0;
                  state_in  = ST_IDLE;
               end else if (remainder == '0) begin
                  state_in = ST_CHECK;
               end else if (table_mode_ff) begin
                  if (idx_next < fill_ff) begin
                     idx_in   = idx_next[IDX_W-1:0];
                     state_in = ST_FETCH;
                  end else begin
                     table_mode_in = 1'b0;
                     divisor_in    = last_entry_ff + VALUE_BITS'(1);
                     state_in      = ST_SDIV;
                  end
               end else begin
                  divisor_in = divisor_ff + VALUE_BITS'(1);
                  state_in   = ST_SDIV;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         upper_ff      <= '0;
         fast_ff       <= 1'b1;
         next_ff       <= VALUE_BITS'(2);
         spent_ff      <= 1'b0;
         fill_ff       <= '0;
         count_ff      <= '0;
         latest_ff     <= '0;
         table_mode_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         upper_ff      <= upper_in;
         fast_ff       <= fast_in;
         next_ff       <= next_in;
         spent_ff      <= spent_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         latest_ff     <= latest_in;
         table_mode_ff <= table_mode_in;
         strobe_ff     <= strobe_in;
      end
      cand_ff       <= cand_in;
      divisor_ff    <= divisor_in;
      last_entry_ff <= last_entry_in;
      idx_ff        <= idx_in;
      value_ff      <= value_in;
      total_ff      <= total_in;
      done_ff       <= done_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_strobe      = strobe_ff;
   assign rsp_prime_value = value_ff;
   assign rsp_prime_total = total_ff;
   assign rsp_is_done     = done_ff;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the trial division prime generator
module tb_top;
   import tdpg_pkg::*;

   localparam int              TABLE_DEPTH = 4096;
   localparam int              TIDX_W      = $clog2(TABLE_DEPTH);
   localparam longint unsigned VALUE_MAX   = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] value;
      logic [31:0] total;
      logic        done;
   } prime_result_type;

   typedef struct {
      bit restart;
      bit wait_drain;
   } prime_request_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic                   req_restart;
   logic                   rsp_strobe;
   logic [RESULT_W-1:0]    rsp_prime_value;
   logic [RESULT_W-1:0]    rsp_prime_total;
   logic                   rsp_is_done;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   prime_request_type pending_requests[$];
   prime_result_type  expected_primes[$];
   int              queued_count  = 0;
   int              offered_count = 0;
   int              taken_count   = 0;
   int              error_count   = 0;
   int              idle_pct      = 0;

   // own copy of the search state and registers
   logic [31:0]     limit_reg;
   logic            fast_reg;
   longint unsigned search_next;
   logic [31:0]     prime_store [TABLE_DEPTH];
   int              stored_count;
   logic [31:0]     primes_found;
   logic [31:0]     last_prime;
   bit              range_exhausted;

   trial_division_prime_generator i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_restart     (req_restart),
      .rsp_strobe      (rsp_strobe),
      .rsp_prime_value (rsp_prime_value),
      .rsp_prime_total (rsp_prime_total),
      .rsp_is_done     (rsp_is_done),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   task automatic flag_error(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic bit divides_by_none(longint unsigned n);
      longint unsigned d;
      longint unsigned p;
      d = 2;
      if (n < 2) return 1'b0;
      if (fast_reg) begin
         for (int i = 0; i < stored_count; i++) begin
            p = 64'(prime_store[TIDX_W'(i)]);
            if (p * p > n) return 1'b1;
            if (n % p == 0) return 1'b0;
         end
         if (stored_count > 0) begin
            p = 64'(prime_store[TIDX_W'(stored_count-1)]);
            d = p + 1;
         end
      end
      while (d * d <= n) begin
         if (n % d == 0) return 1'b0;
         d++;
      end
      return 1'b1;
   endfunction

   function automatic prime_result_type next_prime_step(bit restart);
      prime_result_type res;
      longint unsigned  cand;
      if (restart) begin
         search_next     = 2;
         stored_count    = 0;
         primes_found    = '0;
         last_prime      = '0;
         range_exhausted = 1'b0;
      end
      while (!range_exhausted && search_next <= limit_reg) begin
         cand = search_next;
         if (cand >= VALUE_MAX) begin
            range_exhausted = 1'b1;
         end else begin
            search_next = cand + 1;
         end
         if (divides_by_none(cand)) begin
            primes_found = primes_found + 1;
            last_prime   = cand[31:0];
            if (stored_count < TABLE_DEPTH) begin
               prime_store[TIDX_W'(stored_count)] = cand[31:0];
               stored_count++;
            end
            res.value = last_prime;
            res.total = primes_found;
            res.done  = 1'b0;
            return res;
         end
      end
      res.value = last_prime;
      res.total = primes_found;
      res.done  = 1'b1;
      return res;
   endfunction

   task automatic queue_item(bit restart, bit wait_drain = 1'b0);
      prime_request_type r;
      r.restart    = restart;
      r.wait_drain = wait_drain;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   task automatic wait_idle();
      while (taken_count != queued_count || expected_primes.size() != 0 || busy) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == CSR_UPPER_LIMIT) begin
         limit_reg = data;
      end else begin
         fast_reg = data[0];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset && (!start || taken_count == offered_count)) begin
         if (pending_requests.size() != 0 &&
             !(pending_requests[0].wait_drain && expected_primes.size() != 0) &&
             $urandom_range(99) >= idle_pct) begin
            req_restart   <= pending_requests.pop_front().restart;
            start         <= 1'b1;
            offered_count <= offered_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      prime_result_type want;
      if (!reset) begin
         if (start && !busy) begin
            taken_count <= taken_count + 1;
            expected_primes.push_back(next_prime_step(req_restart));
         end
         if (rsp_strobe) begin
            if (expected_primes.size() == 0) begin
               flag_error($sformatf("unexpected item value %0d total %0d done %0b",
                                    rsp_prime_value, rsp_prime_total, rsp_is_done));
            end else begin
               want = expected_primes.pop_front();
               if (rsp_prime_value !== want.value)
                  flag_error($sformatf("prime_value %0d, want %0d",
                                       rsp_prime_value, want.value));
               if (rsp_prime_total !== want.total)
                  flag_error($sformatf("prime_total %0d, want %0d",
                                       rsp_prime_total, want.total));
               if (rsp_is_done !== want.done)
                  flag_error($sformatf("is_done %0b, want %0b", rsp_is_done, want.done));
            end
         end
      end
   end

   initial begin
      #400_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int          random_items;
      int          phase;
      int          n;
      logic [31:0] lim;

      reset       = 1'b1;
      start       = 1'b0;
      req_restart = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_UPPER_LIMIT;
      csr_wdata   = '0;
      limit_reg   = '0;
      fast_reg    = 1'b1;
      void'(next_prime_step(1'b1));
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // limit below two straight after reset
      queue_item(1'b0);
      queue_item(1'b1);
      wait_idle();
      write_csr(CSR_UPPER_LIMIT, 32'd1);
      queue_item(1'b0);
      wait_idle();
      // exactly one prime, then done
      write_csr(CSR_UPPER_LIMIT, 32'd2);
      queue_item(1'b0);
      queue_item(1'b0);
      wait_idle();
      idle_pct = 87;
      write_csr(CSR_UPPER_LIMIT, 32'hFFFF_FFFF);
      repeat (6) queue_item(1'b0);
      queue_item(1'b1);
      queue_item(1'b0, 1'b1);
      wait_idle();
      // sequential divisors
      idle_pct = 0;
      write_csr(CSR_FAST_MODE, 32'd0);
      repeat (4) queue_item(1'b0);
      wait_idle();
      // limit lowered below the next candidate, then raised again
      write_csr(CSR_UPPER_LIMIT, 32'd5);
      queue_item(1'b0);
      wait_idle();
      idle_pct = 38;
      write_csr(CSR_UPPER_LIMIT, 32'd40);
      write_csr(CSR_FAST_MODE, 32'd1);
      repeat (3) queue_item(1'b0);
      queue_item(1'b1, 1'b1);
      wait_idle();

      random_items = 0;
      phase        = 0;
      while (random_items < 600) begin
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 87;
            default: idle_pct = 38;
         endcase
         case ($urandom_range(9))
            0:       lim = $urandom_range(3);
            1:       lim = 32'hFFFF_FFFF;
            2:       lim = $urandom() | 32'h8000_0000;
            3, 4:    lim = $urandom_range(60);
            default: lim = $urandom_range(1500);
         endcase
         write_csr(CSR_UPPER_LIMIT, lim);
         write_csr(CSR_FAST_MODE, {31'd0, 1'($urandom_range(1))});
         n = $urandom_range(10, 50);
         queue_item($urandom_range(2) == 0);
         for (int i = 1; i < n; i++) begin
            queue_item($urandom_range(24) == 0, $urandom_range(19) == 0);
         end
         random_items += n;
         phase++;
         wait_idle();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/tdpg_pkg.sv
design/tdpg_divider.sv
design/trial_division_prime_generator.sv
dv/tb_top.sv
